// ----- hw/rtl/grid_raycast_column_macros.svh -----
// ----------------------------------------------------------------------------
// Grid ray caster assertion macros
// Concurrent assertion helpers shared by the RTL; compiled out with ASSERT_OFF.
// ----------------------------------------------------------------------------
`ifndef GRID_RAYCAST_COLUMN_MACROS_SVH
`define GRID_RAYCAST_COLUMN_MACROS_SVH
`ifndef ASSERT_OFF
// Same-cycle implication, disabled during reset.
`define GRC_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// Next-cycle implication, disabled during reset.
`define GRC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define GRC_ASSERT_NOW(label, clk, rst, ante, cons, msg)
`define GRC_ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif
`endif

// ----- hw/rtl/grc_pkg.sv -----
// ----------------------------------------------------------------------------
// Grid ray caster package
// Shared types, sizes and codes of the column ray caster.
// ----------------------------------------------------------------------------
package grc_pkg;

   localparam int MAP_DIM       = 32;
   localparam int MAP_BITS      = $clog2(MAP_DIM);
   localparam int MAP_DEPTH     = MAP_DIM * MAP_DIM;
   localparam int MAP_ADDR_W    = $clog2(MAP_DEPTH);
   localparam int MAX_COLUMNS   = 1024;
   localparam int TEXTURE_WIDTH = 64;
   localparam int TEX_BITS      = $clog2(TEXTURE_WIDTH);
   localparam int TEX_T_W       = TEX_BITS + 1;
   localparam int TEX_SQ_W      = 2 * TEX_BITS + 1;

   // Shared divider width covers the shade numerator.
   localparam int DIV_W     = 34;
   localparam int DIV_CNT_W = $clog2(DIV_W);

   localparam logic [DIV_W-1:0] SHADE_NUM  = 34'd10695475200;
   localparam logic [DIV_W-1:0] SHADE_BASE = 34'd41943040;

   localparam logic OP_WRITE = 1'b0;
   localparam logic OP_CAST  = 1'b1;

   localparam logic [2:0] CSR_FOV       = 3'd0;
   localparam logic [2:0] CSR_COLUMNS   = 3'd1;
   localparam logic [2:0] CSR_ROWS      = 3'd2;
   localparam logic [2:0] CSR_STEP      = 3'd3;
   localparam logic [2:0] CSR_LIMIT     = 3'd4;
   localparam logic [2:0] CSR_MAP_COLS  = 3'd5;
   localparam logic [2:0] CSR_MAP_ROWS  = 3'd6;

   typedef struct packed {
      logic        opcode;
      logic [4:0]  cell_x;
      logic [4:0]  cell_y;
      logic        cell_is_wall;
      logic [15:0] viewer_x;
      logic [15:0] viewer_y;
      logic [15:0] view_angle;
      logic [9:0]  column_index;
   } req_type;

   typedef struct packed {
      logic [9:0]  column_out;
      logic        wall_hit;
      logic [15:0] hit_distance;
      logic [9:0]  slice_top;
      logic [9:0]  slice_bottom;
      logic [5:0]  texture_column;
      logic [7:0]  shade_level;
   } rsp_type;

   typedef struct packed {
      logic             start;
      logic [DIV_W-1:0] num;
      logic [DIV_W-1:0] den;
   } div_req_type;

endpackage

// ----- hw/rtl/grc_ram.sv -----
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module grc_ram #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

// ----- hw/rtl/grc_div.sv -----
// ----------------------------------------------------------------------------
// Grid ray caster divider
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module grc_div (
   input  logic                      clock,
   input  logic                      reset,
   input  grc_pkg::div_req_type      div_req,
   output logic                      div_done,
   output logic [grc_pkg::DIV_W-1:0] div_quot
);

   logic                          busy_ff, busy_in;
   logic                          done_ff, done_in;
   logic [grc_pkg::DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic [grc_pkg::DIV_W:0]       rem_ff, rem_in;
   logic [grc_pkg::DIV_W-1:0]     quo_ff, quo_in;
   logic [grc_pkg::DIV_W-1:0]     den_ff, den_in;
   logic [grc_pkg::DIV_W:0]       rem_sh;
   logic [grc_pkg::DIV_W:0]       diff;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      den_in  = den_ff;
      rem_sh  = {rem_ff[grc_pkg::DIV_W-1:0], quo_ff[grc_pkg::DIV_W-1]};
      diff    = rem_sh - {1'b0, den_ff};
      if (div_req.start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = '0;
         quo_in  = div_req.num;
         den_in  = div_req.den;
      end else if (busy_ff) begin
         if (!diff[grc_pkg::DIV_W]) begin
            rem_in = diff;
            quo_in = {quo_ff[grc_pkg::DIV_W-2:0], 1'b1};
         end else begin
            rem_in = rem_sh;
            quo_in = {quo_ff[grc_pkg::DIV_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == grc_pkg::DIV_CNT_W'(grc_pkg::DIV_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      den_ff <= den_in;
   end

   assign div_done = done_ff;
   assign div_quot = quo_ff;

endmodule

// ----- hw/rtl/grid_raycast_column.sv -----
// ----------------------------------------------------------------------------
// Grid ray caster, one screen column per request
// A cast runs the angle division, the sine and the cosine, then the march
// steps; a hit goes on to the height division, the texture search and the
// shade division. One request at a time; busy drops with the result strobe,
// so the next request can be taken in that cycle. A map write leaves the
// block idle. The receiver cannot stall: each result is a one-cycle strobe.
// Reset loads the configuration defaults and then runs a pass that empties
// the map, with busy high; configuration writes are taken throughout.
// ----------------------------------------------------------------------------
`include "grid_raycast_column_macros.svh"

module grid_raycast_column (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  grc_pkg::req_type req_data,
   output logic             rsp_strobe,
   output grc_pkg::rsp_type rsp_data,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [2:0]       csr_index,
   input  logic [15:0]      csr_data
);

   // One-hot sequencer. Each march step runs MUL (point), ADDR (bounds and
   // map read) and CHK (map data back).
   typedef enum logic [16:0] {
      ST_CLEAR    = 17'h00001,
      ST_IDLE     = 17'h00002,
      ST_ANG_GO   = 17'h00004,
      ST_ANG_WAIT = 17'h00008,
      ST_TRIG     = 17'h00010,
      ST_MUL      = 17'h00020,
      ST_ADDR     = 17'h00040,
      ST_CHK      = 17'h00080,
      ST_H_GO     = 17'h00100,
      ST_H_WAIT   = 17'h00200,
      ST_TEX_SQ   = 17'h00400,
      ST_TEX_SUM  = 17'h00800,
      ST_TEX_LOOP = 17'h01000,
      ST_SH_SQ    = 17'h02000,
      ST_SH_GO    = 17'h04000,
      ST_SH_WAIT  = 17'h08000,
      ST_SPARE    = 17'h10000
   } state_type;

   state_type state_ff, state_in;

   // Configuration registers.
   logic [14:0] fov_ff;
   logic [10:0] cols_ff;
   logic [10:0] rows_ff;
   logic [11:0] step_ff;
   logic [15:0] limit_ff;
   logic [5:0]  mapc_ff;
   logic [5:0]  mapr_ff;

   logic [10:0] cols_eff;
   logic [10:0] rows_eff;
   logic [11:0] step_eff;
   logic [5:0]  mx_eff;
   logic [5:0]  my_eff;

   // Work registers of the cast in flight.
   grc_pkg::req_type             req_ff, req_in;
   logic [15:0]                  angle_ff, angle_in;
   logic [1:0]                   tstep_ff, tstep_in;
   logic                         tsel_ff, tsel_in;
   logic [14:0]                  z_ff, z_in;
   logic [14:0]                  z2_ff, z2_in;
   logic [14:0]                  acc_ff, acc_in;
   logic signed [15:0]           ex_ff, ex_in;
   logic signed [15:0]           ey_ff, ey_in;
   logic [16:0]                  d_ff, d_in;
   logic signed [20:0]           px_ff, px_in;
   logic signed [20:0]           py_ff, py_in;
   logic [21:0]                  h_ff, h_in;
   logic [20:0]                  ax2_ff, ax2_in;
   logic [20:0]                  ay2_ff, ay2_in;
   logic [21:0]                  r2_ff, r2_in;
   logic [grc_pkg::TEX_T_W-1:0]  t_ff, t_in;
   logic [grc_pkg::TEX_SQ_W-1:0] tsq_ff, tsq_in;
   logic [33:0]                  dd_ff, dd_in;
   logic [grc_pkg::MAP_ADDR_W-1:0] clear_ff, clear_in;
   grc_pkg::rsp_type             rsp_ff, rsp_in;
   logic                         strobe_ff, strobe_in;

   // Sine sequencer operands.
   logic [15:0] trig_ang;
   logic [1:0]  quad;
   logic [9:0]  quad_r;
   logic [14:0] zc;
   logic [15:0] mul_a, mul_b;
   logic [31:0] mul_p;

   // March datapath.
   logic signed [33:0] prodx, prody;
   logic [8:0]         tx, ty;
   logic               outside;
   logic [10:0]        ax, ay;
   logic [34:0]        tex_lhs;
   logic [34:0]        tex_rhs;

   // Slice rows.
   logic [9:0]  rows_half;
   logic [20:0] h_half;
   logic [9:0]  top_w;
   logic [21:0] bot_full;
   logic [9:0]  bot_w;

   grc_pkg::div_req_type      div_req;
   logic                      div_done;
   logic [grc_pkg::DIV_W-1:0] div_quot;

   logic                           ram_we;
   logic [grc_pkg::MAP_ADDR_W-1:0] ram_waddr;
   logic                           ram_wdata;
   logic [grc_pkg::MAP_ADDR_W-1:0] ram_raddr;
   logic                           ram_rdata;

   logic accept;

   assign busy      = (state_ff != ST_IDLE);
   assign accept    = start && !busy;
   assign csr_ready = 1'b1;

   // Configuration writes land whenever presented; the caller keeps them to
   // idle periods.
   always_ff @(posedge clock) begin
      if (reset) begin
         fov_ff   <= 15'd10923;
         cols_ff  <= 11'd800;
         rows_ff  <= 11'd600;
         step_ff  <= 12'd102;
         limit_ff <= 16'd40960;
         mapc_ff  <= 6'd20;
         mapr_ff  <= 6'd20;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            grc_pkg::CSR_FOV:      fov_ff   <= csr_data[14:0];
            grc_pkg::CSR_COLUMNS:  cols_ff  <= csr_data[10:0];
            grc_pkg::CSR_ROWS:     rows_ff  <= csr_data[10:0];
            grc_pkg::CSR_STEP:     step_ff  <= csr_data[11:0];
            grc_pkg::CSR_LIMIT:    limit_ff <= csr_data;
            grc_pkg::CSR_MAP_COLS: mapc_ff  <= csr_data[5:0];
            grc_pkg::CSR_MAP_ROWS: mapr_ff  <= csr_data[5:0];
            default: ;
         endcase
      end
   end

   // Degenerate register values are folded into their usable range here.
   always_comb begin
      cols_eff = (cols_ff == 11'd0) ? 11'd1 : cols_ff;
      if (rows_ff < 11'd2) begin
         rows_eff = 11'd2;
      end else if (rows_ff > 11'd1024) begin
         rows_eff = 11'd1024;
      end else begin
         rows_eff = rows_ff;
      end
      step_eff = (step_ff == 12'd0) ? 12'd1 : step_ff;
      mx_eff   = (32'(mapc_ff) > grc_pkg::MAP_DIM) ? 6'(grc_pkg::MAP_DIM) : mapc_ff;
      my_eff   = (32'(mapr_ff) > grc_pkg::MAP_DIM) ? 6'(grc_pkg::MAP_DIM) : mapr_ff;
   end

   // The cosine is the sine a quarter turn ahead. Each quadrant folds onto
   // the quarter-wave polynomial, evaluated over four multiplier passes.
   always_comb begin
      trig_ang = tsel_ff ? angle_ff : angle_ff + 16'd16384;
      quad     = trig_ang[15:14];
      quad_r   = trig_ang[13:4];
      zc       = quad[0] ? {(11'd1024 - {1'b0, quad_r}), 4'd0} : {1'b0, quad_r, 4'd0};
      unique case (tstep_ff)
         2'd0: begin
            mul_a = {1'b0, zc};
            mul_b = {1'b0, zc};
         end
         2'd1: begin
            mul_a = 16'd1160;
            mul_b = {1'b0, z2_ff};
         end
         2'd2: begin
            mul_a = {1'b0, z2_ff};
            mul_b = {1'b0, acc_ff};
         end
         default: begin
            mul_a = {1'b0, z_ff};
            mul_b = {1'b0, acc_ff};
         end
      endcase
      mul_p = mul_a * mul_b;
   end

   // March point: the arithmetic right shift floors the scaled direction.
   always_comb begin
      prodx   = ex_ff * $signed({1'b0, d_ff});
      prody   = ey_ff * $signed({1'b0, d_ff});
      px_in   = $signed({5'd0, req_ff.viewer_x}) + $signed({prodx[33], prodx[33:14]});
      py_in   = $signed({5'd0, req_ff.viewer_y}) + $signed({prody[33], prody[33:14]});
      tx      = px_ff[19:11];
      ty      = py_ff[19:11];
      outside = px_ff[20] || py_ff[20] || (tx >= {3'd0, mx_eff}) || (ty >= {3'd0, my_eff});
      ram_raddr = grc_pkg::MAP_ADDR_W'(32'(tx) * grc_pkg::MAP_DIM + 32'(ty));
      // Distance from the cell centre: the low bits above it, 1024 minus them below.
      ax = px_ff[10] ? {1'b0, px_ff[9:0]} : 11'd1024 - {1'b0, px_ff[9:0]};
      ay = py_ff[10] ? {1'b0, py_ff[9:0]} : 11'd1024 - {1'b0, py_ff[9:0]};
      tex_lhs = 35'(tsq_ff) * 35'(r2_ff);
      tex_rhs = 35'({ax2_ff, {(2 * grc_pkg::TEX_BITS){1'b0}}});
   end

   // Slice rows from the slice height.
   always_comb begin
      rows_half = rows_eff[10:1];
      h_half    = h_ff[21:1];
      top_w     = (h_half >= 21'(rows_half)) ? 10'd0 : rows_half - h_half[9:0];
      bot_full  = 22'(rows_half) + 22'(h_half);
      bot_w     = (bot_full >= 22'(rows_eff)) ? 10'(rows_eff - 11'd1) : bot_full[9:0];
   end

   // Map write port: the clearing pass after reset, otherwise write requests.
   always_comb begin
      ram_we    = 1'b0;
      ram_waddr = clear_ff;
      ram_wdata = 1'b0;
      if (state_ff == ST_CLEAR) begin
         ram_we = 1'b1;
      end else if (accept && (req_data.opcode == grc_pkg::OP_WRITE)
                   && (32'(req_data.cell_x) < grc_pkg::MAP_DIM)
                   && (32'(req_data.cell_y) < grc_pkg::MAP_DIM)) begin
         ram_we    = 1'b1;
         ram_waddr = grc_pkg::MAP_ADDR_W'(32'(req_data.cell_x) * grc_pkg::MAP_DIM
                                          + 32'(req_data.cell_y));
         ram_wdata = req_data.cell_is_wall;
      end
   end

   // Main sequencer.
   always_comb begin
      state_in  = state_ff;
      req_in    = req_ff;
      angle_in  = angle_ff;
      tstep_in  = tstep_ff;
      tsel_in   = tsel_ff;
      z_in      = z_ff;
      z2_in     = z2_ff;
      acc_in    = acc_ff;
      ex_in     = ex_ff;
      ey_in     = ey_ff;
      d_in      = d_ff;
      h_in      = h_ff;
      ax2_in    = ax2_ff;
      ay2_in    = ay2_ff;
      r2_in     = r2_ff;
      t_in      = t_ff;
      tsq_in    = tsq_ff;
      dd_in     = dd_ff;
      clear_in  = clear_ff;
      rsp_in    = rsp_ff;
      strobe_in = 1'b0;
      div_req   = '0;

      unique case (state_ff)
         ST_CLEAR: begin
            clear_in = clear_ff + 1'b1;
            if (clear_ff == grc_pkg::MAP_ADDR_W'(grc_pkg::MAP_DEPTH - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept && (req_data.opcode == grc_pkg::OP_CAST)) begin
               req_in   = req_data;
               state_in = ST_ANG_GO;
            end
         end
         ST_ANG_GO: begin
            div_req.start = 1'b1;
            div_req.num   = grc_pkg::DIV_W'(25'(req_ff.column_index) * 25'(fov_ff));
            div_req.den   = grc_pkg::DIV_W'(cols_eff);
            state_in      = ST_ANG_WAIT;
         end
         ST_ANG_WAIT: begin
            if (div_done) begin
               angle_in = req_ff.view_angle - {2'd0, fov_ff[14:1]} + div_quot[15:0];
               tstep_in = 2'd0;
               tsel_in  = 1'b0;
               state_in = ST_TRIG;
            end
         end
         ST_TRIG: begin
            tstep_in = tstep_ff + 2'd1;
            unique case (tstep_ff)
               2'd0: begin
                  z_in  = zc;
                  z2_in = mul_p[28:14];
               end
               2'd1: acc_in = 15'd10512 - mul_p[28:14];
               2'd2: acc_in = 15'd25736 - mul_p[28:14];
               default: begin
                  if (!tsel_ff) begin
                     ex_in   = quad[1] ? -$signed({1'b0, mul_p[28:14]})
                                       : $signed({1'b0, mul_p[28:14]});
                     tsel_in = 1'b1;
                  end else begin
                     ey_in = quad[1] ? -$signed({1'b0, mul_p[28:14]})
                                     : $signed({1'b0, mul_p[28:14]});
                     d_in  = 17'(step_eff);
                     if (limit_ff == 16'd0) begin
                        rsp_in           = '0;
                        rsp_in.column_out = req_ff.column_index;
                        strobe_in        = 1'b1;
                        state_in         = ST_IDLE;
                     end else begin
                        state_in = ST_MUL;
                     end
                  end
               end
            endcase
         end
         ST_MUL: begin
            state_in = ST_ADDR;
         end
         ST_ADDR: begin
            if (outside) begin
               rsp_in            = '0;
               rsp_in.column_out = req_ff.column_index;
               strobe_in         = 1'b1;
               state_in          = ST_IDLE;
            end else begin
               state_in = ST_CHK;
            end
         end
         ST_CHK: begin
            if (ram_rdata) begin
               state_in = ST_H_GO;
            end else if (d_ff < 17'(limit_ff)) begin
               d_in     = d_ff + 17'(step_eff);
               state_in = ST_MUL;
            end else begin
               rsp_in            = '0;
               rsp_in.column_out = req_ff.column_index;
               strobe_in         = 1'b1;
               state_in          = ST_IDLE;
            end
         end
         ST_H_GO: begin
            div_req.start = 1'b1;
            div_req.num   = grc_pkg::DIV_W'({rows_eff, 11'd0});
            div_req.den   = grc_pkg::DIV_W'(d_ff);
            state_in      = ST_H_WAIT;
         end
         ST_H_WAIT: begin
            if (div_done) begin
               h_in     = div_quot[21:0];
               state_in = ST_TEX_SQ;
            end
         end
         ST_TEX_SQ: begin
            ax2_in   = 21'(ax * ax);
            ay2_in   = 21'(ay * ay);
            state_in = ST_TEX_SUM;
         end
         ST_TEX_SUM: begin
            r2_in    = 22'(ax2_ff) + 22'(ay2_ff);
            t_in     = grc_pkg::TEX_T_W'(grc_pkg::TEXTURE_WIDTH);
            tsq_in   = grc_pkg::TEX_SQ_W'(grc_pkg::TEXTURE_WIDTH * grc_pkg::TEXTURE_WIDTH);
            state_in = ST_TEX_LOOP;
         end
         ST_TEX_LOOP: begin
            // Largest t with t*t*r2 no greater than width^2 * ax^2; the square
            // of t steps down by 2t - 1 per pass.
            if (r2_ff == 22'd0) begin
               t_in     = grc_pkg::TEX_T_W'(grc_pkg::TEXTURE_WIDTH - 1);
               state_in = ST_SH_SQ;
            end else if ((t_ff != '0) && (tex_lhs > tex_rhs)) begin
               t_in   = t_ff - 1'b1;
               tsq_in = tsq_ff - grc_pkg::TEX_SQ_W'({t_ff, 1'b0}) + 1'b1;
            end else begin
               if (32'(t_ff) > grc_pkg::TEXTURE_WIDTH - 1) begin
                  t_in = grc_pkg::TEX_T_W'(grc_pkg::TEXTURE_WIDTH - 1);
               end
               state_in = ST_SH_SQ;
            end
         end
         ST_SH_SQ: begin
            dd_in    = 34'(d_ff) * 34'(d_ff);
            state_in = ST_SH_GO;
         end
         ST_SH_GO: begin
            div_req.start = 1'b1;
            div_req.num   = grc_pkg::SHADE_NUM;
            div_req.den   = grc_pkg::SHADE_BASE + dd_ff;
            state_in      = ST_SH_WAIT;
         end
         ST_SH_WAIT: begin
            if (div_done) begin
               rsp_in.column_out     = req_ff.column_index;
               rsp_in.wall_hit       = 1'b1;
               rsp_in.hit_distance   = d_ff[16] ? 16'hFFFF : d_ff[15:0];
               rsp_in.slice_top      = top_w;
               rsp_in.slice_bottom   = bot_w;
               rsp_in.texture_column = t_ff[grc_pkg::TEX_BITS-1:0];
               rsp_in.shade_level    = div_quot[7:0];
               strobe_in             = 1'b1;
               state_in              = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_CLEAR;
         clear_ff  <= '0;
         strobe_ff <= 1'b0;
         tstep_ff  <= 2'd0;
         tsel_ff   <= 1'b0;
      end else begin
         state_ff  <= state_in;
         clear_ff  <= clear_in;
         strobe_ff <= strobe_in;
         tstep_ff  <= tstep_in;
         tsel_ff   <= tsel_in;
      end
      req_ff   <= req_in;
      angle_ff <= angle_in;
      z_ff     <= z_in;
      z2_ff    <= z2_in;
      acc_ff   <= acc_in;
      ex_ff    <= ex_in;
      ey_ff    <= ey_in;
      d_ff     <= d_in;
      px_ff    <= px_in;
      py_ff    <= py_in;
      h_ff     <= h_in;
      ax2_ff   <= ax2_in;
      ay2_ff   <= ay2_in;
      r2_ff    <= r2_in;
      t_ff     <= t_in;
      tsq_ff   <= tsq_in;
      dd_ff    <= dd_in;
      rsp_ff   <= rsp_in;
   end

   assign rsp_strobe = strobe_ff;
   assign rsp_data   = rsp_ff;

   grc_ram #(
      .WIDTH (1),
      .DEPTH (grc_pkg::MAP_DEPTH)
   ) u_map (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   grc_div u_div (
      .clock    (clock),
      .reset    (reset),
      .div_req  (div_req),
      .div_done (div_done),
      .div_quot (div_quot)
   );

   // A cast always takes many cycles, so results never come back to back.
   `GRC_ASSERT_NEXT(a_strobe_single, clock, reset, rsp_strobe, !rsp_strobe, "back to back results")
   // An accepted cast keeps the block busy.
   `GRC_ASSERT_NEXT(a_cast_busy, clock, reset, accept && (req_data.opcode == grc_pkg::OP_CAST), busy, "cast did not raise busy")
   // A miss reports zero distance and shade.
   `GRC_ASSERT_NOW(a_miss_zero, clock, reset, rsp_strobe && !rsp_data.wall_hit, (rsp_data.hit_distance == 16'd0) && (rsp_data.shade_level == 8'd0), "miss with nonzero payload")
   // A wall slice never starts below its end.
   `GRC_ASSERT_NOW(a_slice_order, clock, reset, rsp_strobe && rsp_data.wall_hit, rsp_data.slice_top <= rsp_data.slice_bottom, "slice rows out of order")

endmodule
